[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the tokenizer.
// Each macro samples on the rising clock edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that is already written as an implication.
`define IMT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("imt assertion failed");

// Check that a condition leads to a consequence on the next edge.
`define IMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imt assertion failed");

`endif

[rtl/imt_pkg.sv]
// Types, codes and constants of the IRC message tokenizer.
// Used by every module of the block; has no dependencies of its own.
package imt_pkg;

  // Limits of the message format
  localparam logic [4:0]  MAX_PARAMS = 5'd15;
  localparam logic [4:0]  PARAM_SAT  = 5'd31;
  localparam logic [12:0] TAG_LIMIT  = 13'd8191;
  localparam logic [5:0]  MAX_TAGS   = 6'd63;

  // Characters with a meaning in the line syntax
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_TAGS   = 3'd1,
    PH_HEAD   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_CMD    = 3'd4,
    PH_PARAMS = 3'd5,
    PH_TRAIL  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_KEY   = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_NICK  = 3'd2,
    KIND_SEP   = 3'd3,
    KIND_USER  = 3'd4,
    KIND_HOST  = 3'd5,
    KIND_CMD   = 3'd6,
    KIND_PARAM = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_CMD    = 3'd1,
    ERR_NO_PARAMS = 3'd2,
    ERR_TOO_MANY  = 3'd3,
    ERR_TAG_OVF   = 3'd4
  } err_e;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_e      phase;
    logic        esc_pending;
    logic        in_tag_key;
    logic [5:0]  tag_count;
    logic [12:0] tag_length;
    logic        value_seen;
    logic [1:0]  prefix_part;
    logic [2:0]  parts_seen;
    logic [4:0]  param_count;
    logic        in_token;
    logic        after_space;
    err_e        err;
  } state_t;

  // One result beat
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    kind_e      kind;
    logic [5:0] index;
    logic       field_end;
    logic       tag_has_value;
    logic       full_prefix;
    logic       message_end;
    err_e       err;
  } result_t;

  // Handshake control from the input stage to the result register
  typedef struct packed {
    logic load;
    logic emit;
  } out_ctl_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_START,
    esc_pending: 1'b0,
    in_tag_key:  1'b1,
    tag_count:   6'd0,
    tag_length:  13'd0,
    value_seen:  1'b0,
    prefix_part: 2'd0,
    parts_seen:  3'd0,
    param_count: 5'd0,
    in_token:    1'b0,
    after_space: 1'b0,
    err:         ERR_NONE
  };

  // Field kind of the prefix part in progress
  function automatic kind_e part_kind(input logic [1:0] part);
    kind_e k;
    case (part)
      2'd0:    k = KIND_NICK;
      2'd1:    k = KIND_USER;
      default: k = KIND_HOST;
    endcase
    return k;
  endfunction

endpackage

[rtl/imt_step.sv]
// Per-byte classification: next parser state and the result beat for one byte.
// Pure combinational logic; depends on imt_pkg.
module imt_step (
  input  imt_pkg::state_t  state_i,
  input  logic [7:0]       data_i,
  input  logic             last_i,
  output imt_pkg::state_t  state_o,
  output imt_pkg::result_t res_o,
  output logic             emit_o
);

  imt_pkg::state_t  ns;
  imt_pkg::result_t r;
  logic             emit;
  logic [7:0]       dec;

  // Unescape a tag value byte that follows a backslash
  always_comb begin
    case (data_i)
      imt_pkg::CH_COLON: dec = imt_pkg::CH_SEMI;
      imt_pkg::CH_S:     dec = imt_pkg::CH_SPACE;
      imt_pkg::CH_R:     dec = imt_pkg::CH_CR;
      imt_pkg::CH_N:     dec = imt_pkg::CH_LF;
      default:           dec = data_i;
    endcase
  end

  // Classify the byte and advance the parser
  always_comb begin
    ns   = state_i;
    r    = '0;
    emit = 1'b0;

    case (state_i.phase)
      imt_pkg::PH_START, imt_pkg::PH_HEAD: begin
        if (state_i.phase == imt_pkg::PH_START && data_i == imt_pkg::CH_AT) begin
          ns.phase = imt_pkg::PH_TAGS;
        end else if (data_i == imt_pkg::CH_COLON) begin
          ns.phase    = imt_pkg::PH_PREFIX;
          ns.in_token = 1'b0;
        end else begin
          ns.phase    = imt_pkg::PH_CMD;
          ns.in_token = 1'b0;
          // leading spaces collapse, anything else opens the command
          if (data_i != imt_pkg::CH_SPACE) begin
            ns.in_token = 1'b1;
            emit        = 1'b1;
            r.has_byte  = 1'b1;
            r.data      = data_i;
            r.kind      = imt_pkg::KIND_CMD;
          end
        end
      end

      imt_pkg::PH_TAGS: begin
        if (data_i == imt_pkg::CH_SEMI || data_i == imt_pkg::CH_SPACE) begin
          // close the tag
          emit            = 1'b1;
          r.field_end     = 1'b1;
          r.kind          = state_i.in_tag_key ? imt_pkg::KIND_KEY : imt_pkg::KIND_VALUE;
          r.index         = state_i.tag_count;
          r.tag_has_value = state_i.value_seen;
          if (data_i == imt_pkg::CH_SPACE) begin
            ns.phase = imt_pkg::PH_HEAD;
          end else if (state_i.tag_count < imt_pkg::MAX_TAGS) begin
            ns.tag_count = state_i.tag_count + 6'd1;
            if (ns.tag_count >= imt_pkg::MAX_TAGS && ns.err == imt_pkg::ERR_NONE) begin
              ns.err = imt_pkg::ERR_TAG_OVF;
            end
          end
          ns.in_tag_key  = 1'b1;
          ns.value_seen  = 1'b0;
          ns.tag_length  = '0;
          ns.esc_pending = 1'b0;
        end else begin
          // count raw tag bytes, saturating
          if (state_i.tag_length < imt_pkg::TAG_LIMIT) begin
            ns.tag_length = state_i.tag_length + 13'd1;
            if (ns.tag_length >= imt_pkg::TAG_LIMIT && ns.err == imt_pkg::ERR_NONE) begin
              ns.err = imt_pkg::ERR_TAG_OVF;
            end
          end
          if (state_i.in_tag_key) begin
            if (data_i == imt_pkg::CH_EQ) begin
              ns.in_tag_key = 1'b0;
            end else begin
              emit       = 1'b1;
              r.has_byte = 1'b1;
              r.data     = data_i;
              r.kind     = imt_pkg::KIND_KEY;
              r.index    = state_i.tag_count;
            end
          end else if (state_i.esc_pending) begin
            ns.esc_pending = 1'b0;
            ns.value_seen  = 1'b1;
            emit           = 1'b1;
            r.has_byte     = 1'b1;
            r.data         = dec;
            r.kind         = imt_pkg::KIND_VALUE;
            r.index        = state_i.tag_count;
          end else if (data_i == imt_pkg::CH_BSLASH) begin
            ns.esc_pending = 1'b1;
          end else begin
            ns.value_seen = 1'b1;
            emit          = 1'b1;
            r.has_byte    = 1'b1;
            r.data        = data_i;
            r.kind        = imt_pkg::KIND_VALUE;
            r.index       = state_i.tag_count;
          end
        end
      end

      imt_pkg::PH_PREFIX: begin
        if (data_i == imt_pkg::CH_SPACE) begin
          if (state_i.in_token) begin
            emit          = 1'b1;
            r.field_end   = 1'b1;
            r.kind        = imt_pkg::part_kind(state_i.prefix_part);
            r.full_prefix = &state_i.parts_seen;
            ns.phase      = imt_pkg::PH_CMD;
            ns.in_token   = 1'b0;
          end
        end else begin
          ns.in_token = 1'b1;
          emit        = 1'b1;
          r.has_byte  = 1'b1;
          r.data      = data_i;
          if (state_i.prefix_part == 2'd0 && data_i == imt_pkg::CH_BANG) begin
            r.kind         = imt_pkg::KIND_SEP;
            r.field_end    = 1'b1;
            ns.prefix_part = 2'd1;
          end else if (state_i.prefix_part == 2'd1 && data_i == imt_pkg::CH_AT) begin
            r.kind         = imt_pkg::KIND_SEP;
            r.field_end    = 1'b1;
            ns.prefix_part = 2'd2;
          end else begin
            r.kind = imt_pkg::part_kind(state_i.prefix_part);
            case (state_i.prefix_part)
              2'd0:    ns.parts_seen[0] = 1'b1;
              2'd1:    ns.parts_seen[1] = 1'b1;
              default: ns.parts_seen[2] = 1'b1;
            endcase
          end
        end
      end

      imt_pkg::PH_CMD: begin
        if (data_i == imt_pkg::CH_SPACE) begin
          if (state_i.in_token) begin
            emit           = 1'b1;
            r.field_end    = 1'b1;
            r.kind         = imt_pkg::KIND_CMD;
            ns.phase       = imt_pkg::PH_PARAMS;
            ns.in_token    = 1'b0;
            ns.after_space = 1'b1;
          end
        end else begin
          ns.in_token = 1'b1;
          emit        = 1'b1;
          r.has_byte  = 1'b1;
          r.data      = data_i;
          r.kind      = imt_pkg::KIND_CMD;
        end
      end

      imt_pkg::PH_PARAMS: begin
        if (data_i == imt_pkg::CH_SPACE) begin
          if (state_i.in_token) begin
            emit        = 1'b1;
            r.field_end = 1'b1;
            r.kind      = imt_pkg::KIND_PARAM;
            r.index     = {1'b0, state_i.param_count};
            if (state_i.param_count < imt_pkg::PARAM_SAT) begin
              ns.param_count = state_i.param_count + 5'd1;
            end
            ns.in_token = 1'b0;
          end
          ns.after_space = 1'b1;
        end else if (data_i == imt_pkg::CH_COLON && state_i.after_space) begin
          // open the trailing param
          if (state_i.param_count >= imt_pkg::MAX_PARAMS && ns.err == imt_pkg::ERR_NONE) begin
            ns.err = imt_pkg::ERR_TOO_MANY;
          end
          ns.phase       = imt_pkg::PH_TRAIL;
          ns.after_space = 1'b0;
        end else begin
          if (!state_i.in_token) begin
            if (state_i.param_count >= imt_pkg::MAX_PARAMS &&
                ns.err == imt_pkg::ERR_NONE) begin
              ns.err = imt_pkg::ERR_TOO_MANY;
            end
            ns.in_token = 1'b1;
          end
          ns.after_space = 1'b0;
          emit           = 1'b1;
          r.has_byte     = 1'b1;
          r.data         = data_i;
          r.kind         = imt_pkg::KIND_PARAM;
          r.index        = {1'b0, state_i.param_count};
        end
      end

      imt_pkg::PH_TRAIL: begin
        emit       = 1'b1;
        r.has_byte = 1'b1;
        r.data     = data_i;
        r.kind     = imt_pkg::KIND_PARAM;
        r.index    = {1'b0, state_i.param_count};
      end

      default: begin
        ns.phase = imt_pkg::PH_START;
      end
    endcase

    // Last byte: close the open field, judge the message, rewind
    if (last_i) begin
      emit          = 1'b1;
      r.message_end = 1'b1;
      if (!r.field_end) begin
        if (ns.phase == imt_pkg::PH_TAGS) begin
          r.field_end     = 1'b1;
          r.kind          = ns.in_tag_key ? imt_pkg::KIND_KEY : imt_pkg::KIND_VALUE;
          r.index         = ns.tag_count;
          r.tag_has_value = ns.value_seen;
        end else if (ns.phase == imt_pkg::PH_PREFIX && ns.in_token) begin
          r.field_end   = 1'b1;
          r.kind        = imt_pkg::part_kind(ns.prefix_part);
          r.index       = '0;
          r.full_prefix = &ns.parts_seen;
        end else if (ns.phase == imt_pkg::PH_CMD && ns.in_token) begin
          r.field_end = 1'b1;
          r.kind      = imt_pkg::KIND_CMD;
          r.index     = '0;
        end else if ((ns.phase == imt_pkg::PH_PARAMS && ns.in_token) ||
                     ns.phase == imt_pkg::PH_TRAIL) begin
          r.field_end = 1'b1;
          r.kind      = imt_pkg::KIND_PARAM;
          r.index     = {1'b0, ns.param_count};
        end
      end
      if (ns.err != imt_pkg::ERR_NONE) begin
        r.err = ns.err;
      end else begin
        case (ns.phase)
          imt_pkg::PH_CMD: begin
            r.err = ns.in_token ? imt_pkg::ERR_NO_PARAMS : imt_pkg::ERR_NO_CMD;
          end
          imt_pkg::PH_PARAMS: begin
            r.err = (state_i.phase == imt_pkg::PH_CMD) ? imt_pkg::ERR_NO_PARAMS
                                                       : imt_pkg::ERR_NONE;
          end
          imt_pkg::PH_TRAIL: r.err = imt_pkg::ERR_NONE;
          default:           r.err = imt_pkg::ERR_NO_CMD;
        endcase
      end
      ns = imt_pkg::STATE_RESET;
    end
  end

  assign state_o = ns;
  assign res_o   = r;
  assign emit_o  = emit;

endmodule

[rtl/imt_out_reg.sv]
// Result register of the tokenizer: holds one beat until the sink takes it.
// Depends on imt_pkg for the result and control types.
module imt_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  imt_pkg::out_ctl_t ctl_i,
  input  imt_pkg::result_t res_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output imt_pkg::result_t res_o,
  output logic             free_o
);

  logic             valid_q, valid_d;
  imt_pkg::result_t res_q;

  // Free when empty or when the held beat leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  // Load on a new beat, drop a beat once taken
  always_comb begin
    if (ctl_i.load) begin
      valid_d = ctl_i.emit;
    end else begin
      valid_d = valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload: capture only when a beat is loaded
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && ctl_i.emit) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[rtl/irc_message_tokenizer.sv]
// IRC message tokenizer, top level. An accepted byte passes two registers on the way to its
// result beat (input register, then result register). Throughput: one byte per cycle;
// the input register and parser state advance whenever the result register is free.
// Bytes that make no result leave no beat. Reset (rst_ni low, asynchronous) empties
// both registers and returns the parser to the start of a message.
// Depends on imt_pkg, imt_step and imt_out_reg.
module irc_message_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       has_byte_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] field_kind_o,
  output logic [5:0] field_index_o,
  output logic       field_end_o,
  output logic       tag_has_value_o,
  output logic       full_prefix_o,
  output logic       message_end_o,
  output logic [2:0] error_code_o
);

  logic              in_vld_q, in_vld_d;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              out_free;
  logic              advance;
  logic              accept;
  logic              emit;
  imt_pkg::state_t   state_q, state_d;
  imt_pkg::result_t  step_res, out_res;
  imt_pkg::out_ctl_t out_ctl;

  // Input stage handshake
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Capture the byte beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  imt_step u_step (
    .state_i (state_q),
    .data_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .res_o   (step_res),
    .emit_o  (emit)
  );

  // Parser state: advance with each byte that moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imt_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_ctl.load = advance;
  assign out_ctl.emit = emit;

  imt_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (out_ctl),
    .res_i       (step_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res),
    .free_o      (out_free)
  );

  assign has_byte_o      = out_res.has_byte;
  assign out_byte_o      = out_res.data;
  assign field_kind_o    = out_res.kind;
  assign field_index_o   = out_res.index;
  assign field_end_o     = out_res.field_end;
  assign tag_has_value_o = out_res.tag_has_value;
  assign full_prefix_o   = out_res.full_prefix;
  assign message_end_o   = out_res.message_end;
  assign error_code_o    = out_res.err;

endmodule

[rtl/imt_checker.sv]
// Port-level checks of the IRC message tokenizer, bound to the top level.
// Depends on assert_macros.svh and imt_pkg.
`include "assert_macros.svh"

module imt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] data_byte_i,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       has_byte_o,
  input logic [7:0] out_byte_o,
  input logic [2:0] field_kind_o,
  input logic [5:0] field_index_o,
  input logic       field_end_o,
  input logic       tag_has_value_o,
  input logic       full_prefix_o,
  input logic       message_end_o,
  input logic [2:0] error_code_o
);

  logic [8:0]  in_bits;
  logic [24:0] res_bits;

  // Gather each beat's payload for the hold checks
  assign in_bits  = {last_byte_i, data_byte_i};
  assign res_bits = {has_byte_o, out_byte_o, field_kind_o, field_index_o, field_end_o,
                     tag_has_value_o, full_prefix_o, message_end_o, error_code_o};

  // A stalled input beat stays offered and unchanged
  `IMT_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(in_bits))

  // A stalled result beat stays up
  `IMT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result beat keeps its whole payload
  `IMT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(res_bits))

  // An error code only rides on the end of a message
  `IMT_ASSERT(a_err_at_end, clk_i, rst_ni, out_valid_o && !message_end_o |-> error_code_o == imt_pkg::ERR_NONE)

  // The tag value flag only marks the end of a tag key or value
  `IMT_ASSERT(a_tagval_at_tag_end, clk_i, rst_ni, out_valid_o && tag_has_value_o |-> field_end_o && (field_kind_o == imt_pkg::KIND_KEY || field_kind_o == imt_pkg::KIND_VALUE))

endmodule

bind irc_message_tokenizer imt_checker u_imt_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of irc_message_tokenizer: drives IRC lines byte by byte and
// compares every result beat with a built-in tokenizer model. Depends on imt_pkg.
module testbench;
  import imt_pkg::*;

  typedef logic [7:0] bytes_t[$];

  localparam int HOLD_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       has_byte_o;
  logic [7:0] out_byte_o;
  logic [2:0] field_kind_o;
  logic [5:0] field_index_o;
  logic       field_end_o;
  logic       tag_has_value_o;
  logic       full_prefix_o;
  logic       message_end_o;
  logic [2:0] error_code_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int stall_left = 0;
  int mismatches = 0;

  // Tokenizer state of the model
  phase_e   ps_phase;
  bit       esc_open, key_open, value_nonempty, token_open, space_before;
  int       tag_num, tag_bytes, param_num;
  bit [1:0] pfx_part;
  bit [2:0] pfx_seen;
  err_e     sticky_err;

  // Beat under construction and the beats still owed by the block
  result_t  pend;
  bit       pend_emit;
  result_t  expected_beats[$];

  irc_message_tokenizer i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .has_byte_o      (has_byte_o),
    .out_byte_o      (out_byte_o),
    .field_kind_o    (field_kind_o),
    .field_index_o   (field_index_o),
    .field_end_o     (field_end_o),
    .tag_has_value_o (tag_has_value_o),
    .full_prefix_o   (full_prefix_o),
    .message_end_o   (message_end_o),
    .error_code_o    (error_code_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_line_state();
    ps_phase       = PH_START;
    esc_open       = 1'b0;
    key_open       = 1'b1;
    tag_num        = 0;
    tag_bytes      = 0;
    value_nonempty = 1'b0;
    pfx_part       = 2'd0;
    pfx_seen       = 3'd0;
    param_num      = 0;
    token_open     = 1'b0;
    space_before   = 1'b0;
    sticky_err     = ERR_NONE;
  endfunction

  function automatic void latch_err(err_e e);
    if (sticky_err == ERR_NONE) sticky_err = e;
  endfunction

  function automatic kind_e prefix_kind();
    if (pfx_part == 2'd0) return KIND_NICK;
    if (pfx_part == 2'd1) return KIND_USER;
    return KIND_HOST;
  endfunction

  function automatic void put_byte(kind_e k, int idx, logic [7:0] b);
    pend_emit     = 1'b1;
    pend.has_byte = 1'b1;
    pend.data     = b;
    pend.kind     = k;
    pend.index    = idx[5:0];
  endfunction

  function automatic void mark_end(kind_e k, int idx);
    pend_emit      = 1'b1;
    pend.field_end = 1'b1;
    pend.kind      = k;
    pend.index     = idx[5:0];
  endfunction

  // Command bytes: a space after the name ends it and opens the params
  function automatic void command_byte(logic [7:0] b);
    if (b == CH_SPACE) begin
      if (token_open) begin
        mark_end(KIND_CMD, 0);
        ps_phase     = PH_PARAMS;
        token_open   = 1'b0;
        space_before = 1'b1;
      end
    end else begin
      token_open = 1'b1;
      put_byte(KIND_CMD, 0, b);
    end
  endfunction

  // Advance the model by one byte and queue the beat it owes, if any
  function automatic void tokenize_byte(logic [7:0] b, bit last);
    phase_e     p0;
    logic [7:0] d;
    p0        = ps_phase;
    pend      = '0;
    pend_emit = 1'b0;
    case (ps_phase)
      PH_START, PH_HEAD: begin
        if (ps_phase == PH_START && b == CH_AT) begin
          ps_phase = PH_TAGS;
        end else if (b == CH_COLON) begin
          ps_phase   = PH_PREFIX;
          token_open = 1'b0;
        end else begin
          ps_phase   = PH_CMD;
          token_open = 1'b0;
          command_byte(b);
        end
      end
      PH_TAGS: begin
        if (b == CH_SEMI || b == CH_SPACE) begin
          mark_end(key_open ? KIND_KEY : KIND_VALUE, tag_num);
          pend.tag_has_value = value_nonempty;
          if (b == CH_SPACE) begin
            ps_phase = PH_HEAD;
          end else if (tag_num < MAX_TAGS) begin
            tag_num++;
            if (tag_num >= MAX_TAGS) latch_err(ERR_TAG_OVF);
          end
          key_open       = 1'b1;
          value_nonempty = 1'b0;
          tag_bytes      = 0;
          esc_open       = 1'b0;
        end else begin
          if (tag_bytes < TAG_LIMIT) begin
            tag_bytes++;
            if (tag_bytes >= TAG_LIMIT) latch_err(ERR_TAG_OVF);
          end
          if (key_open) begin
            if (b == CH_EQ) key_open = 1'b0;
            else put_byte(KIND_KEY, tag_num, b);
          end else if (esc_open) begin
            esc_open = 1'b0;
            case (b)
              CH_COLON: d = CH_SEMI;
              CH_S:     d = CH_SPACE;
              CH_R:     d = CH_CR;
              CH_N:     d = CH_LF;
              default:  d = b;
            endcase
            put_byte(KIND_VALUE, tag_num, d);
            value_nonempty = 1'b1;
          end else if (b == CH_BSLASH) begin
            esc_open = 1'b1;
          end else begin
            put_byte(KIND_VALUE, tag_num, b);
            value_nonempty = 1'b1;
          end
        end
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          if (token_open) begin
            mark_end(prefix_kind(), 0);
            pend.full_prefix = (pfx_seen == 3'b111);
            ps_phase   = PH_CMD;
            token_open = 1'b0;
          end
        end else begin
          token_open = 1'b1;
          if ((pfx_part == 2'd0 && b == CH_BANG) || (pfx_part == 2'd1 && b == CH_AT)) begin
            put_byte(KIND_SEP, 0, b);
            pend.field_end = 1'b1;
            pfx_part++;
          end else begin
            put_byte(prefix_kind(), 0, b);
            pfx_seen[pfx_part] = 1'b1;
          end
        end
      end
      PH_CMD: command_byte(b);
      PH_PARAMS: begin
        if (b == CH_SPACE) begin
          if (token_open) begin
            mark_end(KIND_PARAM, param_num);
            if (param_num < PARAM_SAT) param_num++;
            token_open = 1'b0;
          end
          space_before = 1'b1;
        end else if (b == CH_COLON && space_before) begin
          if (param_num >= MAX_PARAMS) latch_err(ERR_TOO_MANY);
          ps_phase     = PH_TRAIL;
          space_before = 1'b0;
        end else begin
          if (!token_open) begin
            if (param_num >= MAX_PARAMS) latch_err(ERR_TOO_MANY);
            token_open = 1'b1;
          end
          space_before = 1'b0;
          put_byte(KIND_PARAM, param_num, b);
        end
      end
      PH_TRAIL: put_byte(KIND_PARAM, param_num, b);
      default:  ps_phase = PH_START;
    endcase

    // Close whatever is open on the last byte and judge the line
    if (last) begin
      pend_emit         = 1'b1;
      pend.message_end  = 1'b1;
      if (!pend.field_end) begin
        if (ps_phase == PH_TAGS) begin
          mark_end(key_open ? KIND_KEY : KIND_VALUE, tag_num);
          pend.tag_has_value = value_nonempty;
        end else if (ps_phase == PH_PREFIX && token_open) begin
          mark_end(prefix_kind(), 0);
          pend.full_prefix = (pfx_seen == 3'b111);
        end else if (ps_phase == PH_CMD && token_open) begin
          mark_end(KIND_CMD, 0);
        end else if ((ps_phase == PH_PARAMS && token_open) || ps_phase == PH_TRAIL) begin
          mark_end(KIND_PARAM, param_num);
        end
      end
      if (sticky_err != ERR_NONE) begin
        pend.err = sticky_err;
      end else begin
        case (ps_phase)
          PH_CMD:    pend.err = token_open ? ERR_NO_PARAMS : ERR_NO_CMD;
          PH_PARAMS: pend.err = (p0 == PH_CMD) ? ERR_NO_PARAMS : ERR_NONE;
          PH_TRAIL:  pend.err = ERR_NONE;
          default:   pend.err = ERR_NO_CMD;
        endcase
      end
      clear_line_state();
    end
    if (pend_emit) expected_beats.push_back(pend);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin : check_beats
    result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("has_byte", want.has_byte, has_byte_o);
        check_field("out_byte", want.data, out_byte_o);
        check_field("field_kind", want.kind, field_kind_o);
        check_field("field_index", want.index, field_index_o);
        check_field("field_end", want.field_end, field_end_o);
        check_field("tag_has_value", want.tag_has_value, tag_has_value_o);
        check_field("full_prefix", want.full_prefix, full_prefix_o);
        check_field("message_end", want.message_end, message_end_o);
        check_field("error_code", want.err, error_code_o);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_reqs != hold_served) begin
      stall_left  = HOLD_CYCLES;
      hold_served = hold_reqs;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offer one byte at the falling edge and hold it until accepted
  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    tokenize_byte(b, last);
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  task automatic send_line(bytes_t line);
    for (int i = 0; i < line.size(); i++) send_byte(line[i], i == line.size() - 1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic bytes_t text(string s);
    bytes_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == a || v == b);
    return v;
  endfunction

  // Mostly letters, now and then any byte but the two given
  function automatic logic [7:0] word_byte(logic [7:0] a, logic [7:0] b);
    if ($urandom_range(3) == 0) return byte_except(a, b);
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  // Bytes with a meaning in the syntax, mixed with random ones
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(7))
      0:       return CH_SPACE;
      1:       return CH_COLON;
      2:       return CH_AT;
      3:       return CH_BANG;
      4:       return CH_SEMI;
      5:       return CH_EQ;
      6:       return CH_BSLASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Tag value byte, biased toward escape letters
  function automatic logic [7:0] value_byte();
    case ($urandom_range(5))
      0:       return CH_S;
      1:       return CH_R;
      2:       return CH_N;
      3:       return CH_COLON;
      default: return word_byte(CH_SEMI, CH_SPACE);
    endcase
  endfunction

  // Build one line: mostly well formed with random content, some noise
  function automatic bytes_t random_line();
    bytes_t q;
    int     n;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 16)) q.push_back(noise_byte());
      return q;
    end
    // tags
    if ($urandom_range(2) == 0) begin
      q.push_back(CH_AT);
      n = $urandom_range(1, 4);
      for (int t = 0; t < n; t++) begin
        if (t != 0) q.push_back(CH_SEMI);
        repeat ($urandom_range(0, 5)) q.push_back(word_byte(CH_SEMI, CH_SPACE));
        if ($urandom_range(1) == 1) begin
          q.push_back(CH_EQ);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(3) == 0) q.push_back(CH_BSLASH);
            q.push_back(value_byte());
          end
        end
      end
      if ($urandom_range(9) != 0) q.push_back(CH_SPACE);
    end
    // prefix
    if ($urandom_range(2) != 0) begin
      q.push_back(CH_COLON);
      repeat ($urandom_range(0, 6)) q.push_back(word_byte(CH_SPACE, CH_BANG));
      if ($urandom_range(9) < 7) begin
        q.push_back(CH_BANG);
        repeat ($urandom_range(0, 5)) q.push_back(word_byte(CH_SPACE, CH_AT));
        if ($urandom_range(9) < 7) begin
          q.push_back(CH_AT);
          repeat ($urandom_range(0, 8)) q.push_back(word_byte(CH_SPACE, CH_SPACE));
        end
      end
      repeat ($urandom_range(1, 2)) q.push_back(CH_SPACE);
    end
    // command
    if ($urandom_range(3) == 0) begin
      repeat (3) q.push_back(8'h30 + 8'($urandom_range(9)));
    end else begin
      repeat ($urandom_range(1, 6)) q.push_back(8'h41 + 8'($urandom_range(25)));
    end
    // params
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 4);
    repeat (n) begin
      repeat ($urandom_range(1, 3)) q.push_back(CH_SPACE);
      repeat ($urandom_range(1, 6)) q.push_back(word_byte(CH_SPACE, CH_COLON));
    end
    if ($urandom_range(1) == 1) begin
      q.push_back(CH_SPACE);
      q.push_back(CH_COLON);
      repeat ($urandom_range(0, 10)) q.push_back(noise_byte());
    end else if ($urandom_range(9) == 0) begin
      q.push_back(CH_SPACE);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_tags_and_escapes();
    send_line(text("@a=b\\:\\s\\\\\\r\\n\\q;k;=v :n!u@h PRIVMSG #c :hi there"));
    send_line(text("@k=x\\;e=\\ C x"));
    send_line(text("@k=v\\"));
    send_line(text("@;; X y"));
  endtask

  task automatic test_prefix_and_command();
    send_line(text(":n!u@h"));
    send_line(text(":a@b!c@d X y"));
    send_line(text(":nick  CMD a"));
    send_line(text("  PING"));
    send_line(text("PING "));
    send_line(text(" "));
  endtask

  task automatic test_params();
    send_line(text("C a   b  :"));
    send_line(text("C :x"));
    send_line(text("C a :b c :d"));
    send_line({text("C "), 8'h00, CH_SPACE, 8'hFF});
  endtask

  // Param and tag counts up to and past their limits
  task automatic test_limits();
    bytes_t q;
    int     param_runs[3];
    int     tag_runs[3];
    param_runs = '{14, 15, 34};
    tag_runs   = '{62, 63, 66};
    foreach (param_runs[k]) begin
      q = text("C");
      repeat (param_runs[k]) q = {q, text(" p")};
      send_line(q);
    end
    send_line({text("C"), text(" p"), text(" p"), text(" p"), text(" p"), text(" p"),
               text(" p"), text(" p"), text(" p"), text(" p"), text(" p"), text(" p"),
               text(" p"), text(" p"), text(" p"), text(" p"), text(" :t")});
    foreach (tag_runs[k]) begin
      q = text("@");
      repeat (tag_runs[k]) q.push_back(CH_SEMI);
      send_line({q, text("k C x")});
    end
  endtask

  // Hold the receiver off while lines keep coming, so the block stalls its input
  task automatic test_backpressure();
    hold_reqs++;
    send_line(text(":server 001 nick :welcome to the network"));
    send_line(text("@t=1 NOTICE nick :again"));
  endtask

  task automatic test_random_lines(int budget);
    bytes_t line;
    int     sent;
    sent = 0;
    while (sent < budget) begin
      line = random_line();
      send_line(line);
      sent += line.size();
    end
  endtask

  initial begin
    clear_line_state();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 49;
    test_tags_and_escapes();
    test_prefix_and_command();
    test_params();
    test_random_lines(300);
    wait_drain();

    send_idle_pct = 49;
    recv_idle_pct = 19;
    test_random_lines(300);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_limits();
    test_random_lines(250);
    wait_drain();

    if (mismatches == 0) begin
      $display("irc_message_tokenizer test passed");
    end else begin
      $display("irc_message_tokenizer test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("irc_message_tokenizer test failed");
    $finish;
  end

endmodule

[irc_message_tokenizer.f]
+incdir+rtl
rtl/imt_pkg.sv
rtl/imt_step.sv
rtl/imt_out_reg.sv
rtl/irc_message_tokenizer.sv
rtl/imt_checker.sv
tb/sv/testbench.sv
